### hdl/srtb_pkg.sv
// ----------------------------------------------------------------------------
// srtb_pkg
// Shared types and constants for the segmented response time bound block.
// ----------------------------------------------------------------------------
package srtb_pkg;

    localparam int WORD_W = 32;
    localparam int SIZE_W = 16;
    localparam int CAP_W  = 17;
    localparam int PRI_W  = 8;
    localparam int MASK_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_NETWORK,
        MODE_LAYER,
        MODE_KERNEL,
        MODE_BLOCK
    } mode_t;

    typedef enum logic [1:0] {
        REG_OWN_PRIORITY,
        REG_OWN_TPC_MASK,
        REG_CLUSTER_CAP,
        REG_ANALYSIS_MODE
    } reg_idx_t;

    typedef struct packed {
        logic [PRI_W-1:0]  own_priority;
        logic [MASK_W-1:0] own_tpc_mask;
        logic [CAP_W-1:0]  cluster_cap;
        mode_t             analysis_mode;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] own_wcet;
        logic [SIZE_W-1:0] own_size;
        logic              other_valid;
        logic [PRI_W-1:0]  other_priority;
        logic [MASK_W-1:0] other_tpc_mask;
        logic [SIZE_W-1:0] other_size;
        logic [WORD_W-1:0] other_wcet;
        logic              last_other;
        logic              last_segment;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] own_wcet;
        logic [WORD_W-1:0] other_wcet;
        logic              is_block;
        logic              is_intf;
        logic              close;
        logic              last;
    } cls_t;

    typedef struct packed {
        logic [WORD_W-1:0] own_wcet;
        logic [WORD_W-1:0] blk;
        logic [WORD_W-1:0] intf;
        logic              close;
        logic              last;
        logic              ovf;
    } seg_t;

endpackage

### hdl/srtb_cfg.sv
// ----------------------------------------------------------------------------
// srtb_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module srtb_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srtb_pkg::ADDR_W-1:0]  paddr,
    input  logic [srtb_pkg::DATA_W-1:0]  pwdata,
    output logic [srtb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output srtb_pkg::cfg_t               cfg
);

    srtb_pkg::cfg_t     cfg_reg;
    srtb_pkg::cfg_t     cfg_next;
    srtb_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = srtb_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                srtb_pkg::REG_OWN_PRIORITY:
                    cfg_next.own_priority = pwdata[srtb_pkg::PRI_W-1:0];
                srtb_pkg::REG_OWN_TPC_MASK:
                    cfg_next.own_tpc_mask = pwdata[srtb_pkg::MASK_W-1:0];
                srtb_pkg::REG_CLUSTER_CAP:
                    cfg_next.cluster_cap = pwdata[srtb_pkg::CAP_W-1:0];
                srtb_pkg::REG_ANALYSIS_MODE:
                    cfg_next.analysis_mode = srtb_pkg::mode_t'(pwdata[1:0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            srtb_pkg::REG_OWN_PRIORITY:
                prdata = {{(srtb_pkg::DATA_W-srtb_pkg::PRI_W){1'b0}}, cfg_reg.own_priority};
            srtb_pkg::REG_OWN_TPC_MASK:
                prdata = {{(srtb_pkg::DATA_W-srtb_pkg::MASK_W){1'b0}}, cfg_reg.own_tpc_mask};
            srtb_pkg::REG_CLUSTER_CAP:
                prdata = {{(srtb_pkg::DATA_W-srtb_pkg::CAP_W){1'b0}}, cfg_reg.cluster_cap};
            srtb_pkg::REG_ANALYSIS_MODE:
                prdata = {{(srtb_pkg::DATA_W-2){1'b0}}, cfg_reg.analysis_mode};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/srtb_classify.sv
// ----------------------------------------------------------------------------
// srtb_classify
// Input register and conflict classification of each competitor.
// ----------------------------------------------------------------------------
module srtb_classify
#(
    parameter int TPC_COUNT = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  srtb_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  srtb_pkg::item_t in_item,
    input  logic           en1,
    input  logic           en2,
    output logic           v1,
    output logic           v2,
    output srtb_pkg::cls_t cls
);

    localparam logic [srtb_pkg::MASK_W-1:0] TPC_MASK =
        (TPC_COUNT >= srtb_pkg::MASK_W) ? '1 :
        srtb_pkg::MASK_W'((1 << TPC_COUNT) - 1);

    srtb_pkg::item_t item_reg;
    logic            v1_reg;
    srtb_pkg::cls_t  cls_reg;
    srtb_pkg::cls_t  cls_next;
    logic            v2_reg;
    logic            share;
    logic            over_cap;
    logic            conflict;
    logic [srtb_pkg::CAP_W-1:0] size_sum;

    always_comb
    begin
        share    = |(cfg.own_tpc_mask & item_reg.other_tpc_mask & TPC_MASK);
        size_sum = {1'b0, item_reg.own_size} + {1'b0, item_reg.other_size};
        over_cap = size_sum > cfg.cluster_cap;
        conflict = item_reg.other_valid && share &&
                   ((cfg.analysis_mode == srtb_pkg::MODE_NETWORK) || over_cap);

        cls_next.own_wcet   = item_reg.own_wcet;
        cls_next.other_wcet = item_reg.other_wcet;
        cls_next.is_block   = conflict && (item_reg.other_priority > cfg.own_priority);
        cls_next.is_intf    = conflict &&
                              ((item_reg.other_priority < cfg.own_priority) ||
                               ((item_reg.other_priority == cfg.own_priority) &&
                                ((cfg.analysis_mode == srtb_pkg::MODE_KERNEL) ||
                                 (cfg.analysis_mode == srtb_pkg::MODE_BLOCK))));
        cls_next.close      = item_reg.last_other;
        cls_next.last       = item_reg.last_other && item_reg.last_segment;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            item_reg <= in_item;
        end
        if (en2 && v1_reg)
        begin
            cls_reg <= cls_next;
        end
    end

    assign v1  = v1_reg;
    assign v2  = v2_reg;
    assign cls = cls_reg;

endmodule

### hdl/srtb_accum.sv
// ----------------------------------------------------------------------------
// srtb_accum
// Per-segment blocking maximum and saturating interference sum.
// ----------------------------------------------------------------------------
module srtb_accum
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           v2,
    input  srtb_pkg::cls_t cls,
    input  logic           en3,
    output logic           v3,
    output srtb_pkg::seg_t seg
);

    logic [srtb_pkg::WORD_W-1:0] blk_reg;
    logic [srtb_pkg::WORD_W-1:0] blk_next;
    logic [srtb_pkg::WORD_W-1:0] intf_reg;
    logic [srtb_pkg::WORD_W-1:0] intf_next;
    logic [srtb_pkg::WORD_W-1:0] blk_upd;
    logic [srtb_pkg::WORD_W-1:0] intf_upd;
    logic [srtb_pkg::WORD_W:0]   intf_sum;
    logic                        v3_reg;
    srtb_pkg::seg_t              seg_reg;
    srtb_pkg::seg_t              seg_next;
    logic                        step;

    assign step = v2 && en3;

    always_comb
    begin
        blk_upd  = (cls.is_block && (cls.other_wcet > blk_reg)) ? cls.other_wcet : blk_reg;
        intf_sum = {1'b0, intf_reg} +
                   {1'b0, (cls.is_intf ? cls.other_wcet : {srtb_pkg::WORD_W{1'b0}})};
        intf_upd = intf_sum[srtb_pkg::WORD_W] ? '1 : intf_sum[srtb_pkg::WORD_W-1:0];

        seg_next.own_wcet = cls.own_wcet;
        seg_next.blk      = blk_upd;
        seg_next.intf     = intf_upd;
        seg_next.close    = cls.close;
        seg_next.last     = cls.last;
        seg_next.ovf      = intf_sum[srtb_pkg::WORD_W];

        blk_next  = blk_reg;
        intf_next = intf_reg;
        if (step)
        begin
            // segment close empties the per-segment terms
            blk_next  = cls.close ? '0 : blk_upd;
            intf_next = cls.close ? '0 : intf_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg  <= '0;
            intf_reg <= '0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            blk_reg  <= blk_next;
            intf_reg <= intf_next;
            if (en3)
            begin
                v3_reg <= v2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            seg_reg <= seg_next;
        end
    end

    assign v3  = v3_reg;
    assign seg = seg_reg;

endmodule

### hdl/srtb_close.sv
// ----------------------------------------------------------------------------
// srtb_close
// Segment close: response time recurrence and result register.
// ----------------------------------------------------------------------------
module srtb_close
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         v3,
    input  srtb_pkg::seg_t               seg,
    output logic                         f4,
    output logic                         v4,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [srtb_pkg::WORD_W-1:0]  response_time,
    output logic                         saturated
);

    logic [srtb_pkg::WORD_W-1:0] rt_reg;
    logic [srtb_pkg::WORD_W-1:0] blk_reg;
    logic                        close_reg;
    logic                        last_reg;
    logic                        ovf_reg;
    logic                        v4_reg;
    logic [srtb_pkg::WORD_W:0]   rt_sum;
    logic [srtb_pkg::WORD_W-1:0] acc_reg;
    logic [srtb_pkg::WORD_W-1:0] acc_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic [srtb_pkg::WORD_W-1:0] base;
    logic [srtb_pkg::WORD_W:0]   acc_sum;
    logic [srtb_pkg::WORD_W-1:0] acc_new;
    logic                        seen_new;
    logic                        blocked;
    logic                        fire;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [srtb_pkg::WORD_W-1:0] rt_out_reg;
    logic                        sat_out_reg;

    assign rt_sum  = {1'b0, seg.own_wcet} + {1'b0, seg.intf};
    assign blocked = v4_reg && last_reg && out_valid_reg && out_stall;
    assign f4      = !v4_reg || !blocked;
    assign fire    = v4_reg && !blocked;

    always_comb
    begin
        base     = (blk_reg > acc_reg) ? blk_reg : acc_reg;
        acc_sum  = {1'b0, rt_reg} + {1'b0, base};
        acc_new  = acc_sum[srtb_pkg::WORD_W] ? '1 : acc_sum[srtb_pkg::WORD_W-1:0];
        seen_new = seen_reg || ovf_reg || (close_reg && acc_sum[srtb_pkg::WORD_W]);

        acc_next  = acc_reg;
        seen_next = seen_reg;
        if (fire)
        begin
            seen_next = seen_new;
            if (close_reg)
            begin
                acc_next = acc_new;
            end
            // analysis end starts the next one from zero
            if (last_reg)
            begin
                acc_next  = '0;
                seen_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        if (fire && last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (f4)
            begin
                v4_reg <= v3;
            end
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f4 && v3)
        begin
            rt_reg    <= rt_sum[srtb_pkg::WORD_W] ? '1 : rt_sum[srtb_pkg::WORD_W-1:0];
            blk_reg   <= seg.blk;
            close_reg <= seg.close;
            last_reg  <= seg.last;
            ovf_reg   <= seg.ovf || (seg.close && rt_sum[srtb_pkg::WORD_W]);
        end
        if (fire && last_reg)
        begin
            rt_out_reg  <= acc_new;
            sat_out_reg <= seen_new;
        end
    end

    assign v4            = v4_reg;
    assign out_valid     = out_valid_reg;
    assign response_time = rt_out_reg;
    assign saturated     = sat_out_reg;

endmodule

### hdl/segmented_response_time_bound_top.sv
// ----------------------------------------------------------------------------
// segmented_response_time_bound_top
// Streaming response time bound of one task over a sequence of segments.
// ----------------------------------------------------------------------------
// usage
//   configure own_priority, own_tpc_mask, cluster_cap and analysis_mode over
//   the apb port while the block is idle, then stream one competitor per
//   input transfer; last_other closes a segment and last_segment together
//   with last_other closes the analysis and yields one output transfer.
//   both channels use valid/stall; a transfer happens when valid is high and
//   stall is low.
//   throughput: one input transfer per cycle, sustained while in_stall stays low.
//   path: the result of the input transfer that closes the analysis passes
//   through the input register, classify, segment accumulate, response time
//   add and result register stages before it appears on out_valid.
//   a stalled result is held in the output register while further inputs
//   keep flowing; in_stall rises only when a second result reaches the last
//   stage while the first is still stalled and the pipeline behind it fills.
//   reset clears the configuration, all accumulators and the pipeline.
// ----------------------------------------------------------------------------
module segmented_response_time_bound_top
#(
    parameter int TPC_COUNT = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srtb_pkg::ADDR_W-1:0]  paddr,
    input  logic [srtb_pkg::DATA_W-1:0]  pwdata,
    output logic [srtb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [srtb_pkg::WORD_W-1:0]  own_wcet,
    input  logic [srtb_pkg::SIZE_W-1:0]  own_size,
    input  logic                         other_valid,
    input  logic [srtb_pkg::PRI_W-1:0]   other_priority,
    input  logic [srtb_pkg::MASK_W-1:0]  other_tpc_mask,
    input  logic [srtb_pkg::SIZE_W-1:0]  other_size,
    input  logic [srtb_pkg::WORD_W-1:0]  other_wcet,
    input  logic                         last_other,
    input  logic                         last_segment,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [srtb_pkg::WORD_W-1:0]  response_time,
    output logic                         saturated
);

    srtb_pkg::cfg_t  cfg;
    srtb_pkg::item_t in_item;
    srtb_pkg::cls_t  cls;
    srtb_pkg::seg_t  seg;
    logic            v1;
    logic            v2;
    logic            v3;
    logic            v4;
    logic            f1;
    logic            f2;
    logic            f3;
    logic            f4;

    assign in_item.own_wcet       = own_wcet;
    assign in_item.own_size       = own_size;
    assign in_item.other_valid    = other_valid;
    assign in_item.other_priority = other_priority;
    assign in_item.other_tpc_mask = other_tpc_mask;
    assign in_item.other_size     = other_size;
    assign in_item.other_wcet     = other_wcet;
    assign in_item.last_other     = last_other;
    assign in_item.last_segment   = last_segment;

    // a stage may load when it is empty or its content moves on
    assign f3       = !v3 || f4;
    assign f2       = !v2 || f3;
    assign f1       = !v1 || f2;
    assign in_stall = !f1;

    srtb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srtb_classify #(
        .TPC_COUNT (TPC_COUNT)
    ) u_classify
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_item  (in_item),
        .en1      (f1),
        .en2      (f2),
        .v1       (v1),
        .v2       (v2),
        .cls      (cls)
    );

    srtb_accum u_accum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .v2    (v2),
        .cls   (cls),
        .en3   (f3),
        .v3    (v3),
        .seg   (seg)
    );

    srtb_close u_close
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .v3            (v3),
        .seg           (seg),
        .f4            (f4),
        .v4            (v4),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .response_time (response_time),
        .saturated     (saturated)
    );

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1 && v2 && v3 && v4 && out_valid && out_stall)
    ) else $error("input stalled with room in the pipeline");

    a_accept_fills_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1
    ) else $error("accepted transfer missing from input register");

    a_result_from_last_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v4)
    ) else $error("result appeared without an item in the last stage");

endmodule

### sim/tb_segmented_response_time_bound_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_response_time_bound_top
// Self-checking bench for the segmented response time bound block. Competitor
// transfers are streamed in whole analyses, and every accepted transfer also
// goes through a local bound predictor. Results are matched in order against
// the predicted bounds. Register settings change between phases, and the
// sender idles and the receiver stalls at rates set for each phase.
// ----------------------------------------------------------------------------
module tb_segmented_response_time_bound_top;

    localparam int TPC_COUNT     = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [srtb_pkg::MASK_W-1:0] TPC_KEEP =
        srtb_pkg::MASK_W'((65'd1 << TPC_COUNT) - 1);

    typedef struct packed {
        logic [srtb_pkg::WORD_W-1:0] response_time;
        logic                        saturated;
    } bound_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [srtb_pkg::ADDR_W-1:0]   paddr = '0;
    logic [srtb_pkg::DATA_W-1:0]   pwdata = '0;
    logic [srtb_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [srtb_pkg::WORD_W-1:0]   own_wcet = '0;
    logic [srtb_pkg::SIZE_W-1:0]   own_size = '0;
    logic                          other_valid = 1'b0;
    logic [srtb_pkg::PRI_W-1:0]    other_priority = '0;
    logic [srtb_pkg::MASK_W-1:0]   other_tpc_mask = '0;
    logic [srtb_pkg::SIZE_W-1:0]   other_size = '0;
    logic [srtb_pkg::WORD_W-1:0]   other_wcet = '0;
    logic                          last_other = 1'b0;
    logic                          last_segment = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [srtb_pkg::WORD_W-1:0]   response_time;
    logic                          saturated;

    srtb_pkg::item_t pending_items[$];
    srtb_pkg::item_t cur_item;
    bound_t          bounds_due[$];
    bound_t          front_bound;
    srtb_pkg::cfg_t  shadow_cfg = '0;
    logic [31:0]     seg_blocking = '0;
    logic [31:0]     seg_interference = '0;
    logic [31:0]     bound_acc = '0;
    logic            clip_seen = 1'b0;
    int unsigned     items_queued = 0;
    int unsigned     items_accepted = 0;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     fail_count = 0;
    int unsigned     cycle_count = 0;

    segmented_response_time_bound_top #(.TPC_COUNT(TPC_COUNT)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .own_wcet       (own_wcet),
        .own_size       (own_size),
        .other_valid    (other_valid),
        .other_priority (other_priority),
        .other_tpc_mask (other_tpc_mask),
        .other_size     (other_size),
        .other_wcet     (other_wcet),
        .last_other     (last_other),
        .last_segment   (last_segment),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .response_time  (response_time),
        .saturated      (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] clip_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[32])
        begin
            clip_seen = 1'b1;
            return '1;
        end
        return s[31:0];
    endfunction

    task automatic predict_bound(input srtb_pkg::item_t it);
        logic        share;
        logic        conflict;
        logic [31:0] base;
        logic [31:0] seg_rt;
        bound_t      res;
        if (it.other_valid)
        begin
            share = ((shadow_cfg.own_tpc_mask & it.other_tpc_mask) & TPC_KEEP) != '0;
            conflict = share && (shadow_cfg.analysis_mode == srtb_pkg::MODE_NETWORK ||
                ({1'b0, it.own_size} + {1'b0, it.other_size}) > shadow_cfg.cluster_cap);
            if (conflict)
            begin
                if (it.other_priority > shadow_cfg.own_priority)
                begin
                    if (it.other_wcet > seg_blocking)
                        seg_blocking = it.other_wcet;
                end
                else if (it.other_priority < shadow_cfg.own_priority ||
                         shadow_cfg.analysis_mode >= srtb_pkg::MODE_KERNEL)
                    seg_interference = clip_add(seg_interference, it.other_wcet);
            end
        end
        if (it.last_other)
        begin
            base = (seg_blocking > bound_acc) ? seg_blocking : bound_acc;
            seg_rt = clip_add(it.own_wcet, seg_interference);
            bound_acc = clip_add(seg_rt, base);
            seg_blocking = '0;
            seg_interference = '0;
            if (it.last_segment)
            begin
                res.response_time = bound_acc;
                res.saturated = clip_seen;
                bounds_due.push_back(res);
                bound_acc = '0;
                clip_seen = 1'b0;
            end
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_bound(cur_item);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    in_valid       <= 1'b1;
                    own_wcet       <= cur_item.own_wcet;
                    own_size       <= cur_item.own_size;
                    other_valid    <= cur_item.other_valid;
                    other_priority <= cur_item.other_priority;
                    other_tpc_mask <= cur_item.other_tpc_mask;
                    other_size     <= cur_item.other_size;
                    other_wcet     <= cur_item.other_wcet;
                    last_other     <= cur_item.last_other;
                    last_segment   <= cur_item.last_segment;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (bounds_due.size() == 0)
                begin
                    $error("unexpected result transfer: response_time %h saturated %b",
                           response_time, saturated);
                    fail_count++;
                end
                else
                begin
                    front_bound = bounds_due.pop_front();
                    if (response_time !== front_bound.response_time)
                    begin
                        $error("response_time: expected %h, got %h",
                               front_bound.response_time, response_time);
                        fail_count++;
                    end
                    if (saturated !== front_bound.saturated)
                    begin
                        $error("saturated: expected %b, got %b",
                               front_bound.saturated, saturated);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input srtb_pkg::reg_idx_t idx,
                             input logic [srtb_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srtb_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            srtb_pkg::REG_OWN_PRIORITY:
                shadow_cfg.own_priority  = value[srtb_pkg::PRI_W-1:0];
            srtb_pkg::REG_OWN_TPC_MASK:
                shadow_cfg.own_tpc_mask  = value[srtb_pkg::MASK_W-1:0];
            srtb_pkg::REG_CLUSTER_CAP:
                shadow_cfg.cluster_cap   = value[srtb_pkg::CAP_W-1:0];
            srtb_pkg::REG_ANALYSIS_MODE:
                shadow_cfg.analysis_mode = srtb_pkg::mode_t'(value[1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] pri, input logic [7:0] mask,
                                input logic [16:0] cap, input srtb_pkg::mode_t mode);
        write_reg(srtb_pkg::REG_OWN_PRIORITY, srtb_pkg::DATA_W'(pri));
        write_reg(srtb_pkg::REG_OWN_TPC_MASK, srtb_pkg::DATA_W'(mask));
        write_reg(srtb_pkg::REG_CLUSTER_CAP, srtb_pkg::DATA_W'(cap));
        write_reg(srtb_pkg::REG_ANALYSIS_MODE, srtb_pkg::DATA_W'(mode));
    endtask

    // wait for every transfer and result, then let the pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        while ((items_accepted != items_queued || bounds_due.size() != 0) &&
               waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_item(input logic [31:0] ow, input logic [15:0] osz,
                             input logic ov, input logic [7:0] pri,
                             input logic [7:0] mask, input logic [15:0] sz,
                             input logic [31:0] w, input logic lo, input logic ls);
        srtb_pkg::item_t it;
        it.own_wcet       = ow;
        it.own_size       = osz;
        it.other_valid    = ov;
        it.other_priority = pri;
        it.other_tpc_mask = mask;
        it.other_size     = sz;
        it.other_wcet     = w;
        it.last_other     = lo;
        it.last_segment   = ls;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(7))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(255);
            default: return $urandom_range(32'h0040_0000);
        endcase
    endfunction

    function automatic logic [15:0] rand_size();
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(255));
        return 16'($urandom());
    endfunction

    task automatic push_random(input logic ov, input logic lo, input logic ls);
        logic [7:0] pri;
        pri = ($urandom_range(2) == 0) ? shadow_cfg.own_priority : 8'($urandom());
        push_item(rand_time(), rand_size(), ov, pri, 8'($urandom()), rand_size(),
                  rand_time(), lo, ls);
    endtask

    // one well-formed analysis, sometimes preceded by a stray transfer
    task automatic queue_analysis();
        int segs;
        int comps;
        if ($urandom_range(9) == 0)
            push_random(1'b0, 1'b0, 1'($urandom()));
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++)
        begin
            comps = $urandom_range(0, 4);
            for (int c = 0; c < comps; c++)
                push_random(($urandom_range(7) != 0), 1'b0, ($urandom_range(5) == 0));
            push_random(1'($urandom()), 1'b1, (s == segs - 1));
        end
    endtask

    task automatic run_phase(input logic [7:0] pri, input logic [7:0] mask,
                             input logic [16:0] cap, input srtb_pkg::mode_t mode,
                             input int unsigned send_pct, input int unsigned stall_pct,
                             input int unsigned n);
        int unsigned target;
        apply_config(pri, mask, cap, mode);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        target = items_queued + n;
        while (items_queued < target)
            queue_analysis();
        settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_config(8'd100, 8'h0F, 17'd1000, srtb_pkg::MODE_KERNEL);
        // lower priority raises blocking, higher and equal add interference
        push_item(32'h0, 16'd600, 1'b1, 8'd200, 8'h01, 16'd600, 32'h100, 1'b0, 1'b0);
        push_item(32'h0, 16'd600, 1'b1, 8'd255, 8'h08, 16'd600, 32'h300, 1'b0, 1'b0);
        push_item(32'h0, 16'd600, 1'b1, 8'd10, 8'h0F, 16'd600, 32'h1000, 1'b0, 1'b0);
        push_item(32'h0, 16'd600, 1'b1, 8'd100, 8'h02, 16'd600, 32'h20, 1'b0, 1'b0);
        // no cluster overlap, then sizes within capacity
        push_item(32'h0, 16'd600, 1'b1, 8'd0, 8'hF0, 16'd600, 32'h5000, 1'b0, 1'b0);
        push_item(32'h0, 16'd0, 1'b1, 8'd0, 8'hFF, 16'd0, 32'h7000, 1'b0, 1'b0);
        // transfer with nothing in it, final-segment mark without segment end
        push_item(32'h0, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b0, 1'b0);
        push_item(32'h0, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b0, 1'b1);
        // competitor on the closing transfer, then a bare segment close
        push_item(32'h1_0000, 16'hFFFF, 1'b1, 8'd0, 8'h04, 16'hFFFF, 32'h2, 1'b1, 1'b0);
        push_item(32'h2_0000, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b1, 1'b0);
        push_item(32'h3_0000, 16'd700, 1'b1, 8'd255, 8'hFF, 16'd400, 32'hFFFF_FFFF,
                  1'b0, 1'b0);
        push_item(32'h1, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b1, 1'b1);
        push_item(32'h0, 16'hFFFF, 1'b1, 8'd0, 8'hFF, 16'hFFFF, 32'h8000, 1'b0, 1'b0);
        push_item(32'h4000, 16'd1000, 1'b1, 8'd99, 8'h0F, 16'd1, 32'h100, 1'b1, 1'b1);
        // interference clips
        push_item(32'h0, 16'd1000, 1'b1, 8'd0, 8'h0F, 16'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_item(32'h0, 16'd1000, 1'b1, 8'd1, 8'h0F, 16'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_item(32'hFFFF_FFFF, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b1, 1'b1);
        push_item(32'hFFFF_FFFF, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b1, 1'b1);
        push_item(32'h0, 16'd0, 1'b0, 8'd0, 8'h00, 16'd0, 32'h0, 1'b1, 1'b1);
        settle();

        run_phase(8'd0, 8'hFF, 17'd0, srtb_pkg::MODE_NETWORK, 0, 0, 110);
        run_phase(8'd255, 8'h55, 17'd70000, srtb_pkg::MODE_BLOCK, 57, 0, 110);
        run_phase(8'd128, 8'hAA, 17'd65535, srtb_pkg::MODE_LAYER, 0, 57, 110);
        run_phase(8'($urandom()), 8'($urandom()), 17'($urandom()),
                  srtb_pkg::mode_t'($urandom_range(3)), 28, 28, 110);
        run_phase(8'd1, 8'h81, 17'd131071, srtb_pkg::MODE_LAYER, 0, 0, 30);
        run_phase(8'($urandom()), 8'h3C, 17'd40000, srtb_pkg::MODE_KERNEL, 0, 0, 80);

        if (bounds_due.size() != 0)
        begin
            $error("%0d expected results never arrived", bounds_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
